>>> hw/rtl/mmet_pkg.sv
// Shared types and constants of the multi-mode event timer.
package mmet_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int PER_W        = 32;
    localparam int CNT_W        = 16;
    localparam int ACC_W        = 40;
    localparam int AMT_W        = 48;
    localparam int QUO_W        = 41;

    localparam logic       KIND_TICK     = 1'b0;
    localparam logic       KIND_ADD      = 1'b1;
    localparam logic [1:0] MODE_INTERVAL = 2'd2;
    localparam logic [1:0] MODE_LUMPED   = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [PER_W-1:0] period;
        logic [CNT_W-1:0] remaining;
        logic [ACC_W-1:0] accumulated;
        logic [PER_W-1:0] carry;
    } chan_rec_t;

endpackage

>>> hw/rtl/mmet_div.sv
// Restoring divider, one quotient bit per cycle.
module mmet_div
    import mmet_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [PER_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient,
    output logic [PER_W-1:0] remainder
);

    logic [QUO_W-1:0] q_reg;
    logic [PER_W-1:0] r_reg;
    logic [PER_W-1:0] d_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [PER_W:0]   trial;
    logic             fits;

    assign trial = {r_reg, q_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(QUO_W);
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
        end else if (busy_reg) begin
            r_reg    <= fits ? PER_W'(trial - {1'b0, d_reg}) : trial[PER_W-1:0];
            q_reg    <= {q_reg[QUO_W-2:0], fits};
            cnt_reg  <= cnt_reg - 6'd1;
            busy_reg <= (cnt_reg != 6'd1);
            done_reg <= (cnt_reg == 6'd1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> hw/rtl/multi_mode_event_timer.sv
// Top level of the multi-mode event timer: channel memory, sequencer and result stage.
//
//  channel | dir | tdata (lsb first)                                      | tuser / tlast
//  s_      | in  | channel, mode, period, count, start_elapsed,           | tuser: kind
//          |     | immediate, elapsed                                     |
//  m_      | out | fired_channel, fire_times, amount                      | tlast: last
//
// An add request is written to the channel memory when it is accepted; with immediate set
// it is also evaluated, and the catch-up or lumped mode then runs the 41-step divider.
// A tick walks the channels: free channels are skipped, each active channel is loaded,
// evaluated and divided where needed, and the last result is flushed at the end.
// Channel records live in a memory with one read and one write port, and the read is
// registered.
// Reset clears the control, active and valid registers, not the channel memory. A waiting
// result stalls the walk when a second result is ready while the output register is full.
module multi_mode_event_timer
    import mmet_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // channel[2:0] mode[4:3] period[36:5] count[52:37] start_elapsed[84:53]
    // immediate[85] elapsed[117:86]
    input  logic [119:0] s_tdata,
    // kind[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // fired_channel[2:0] fire_times[18:3] amount[66:19]
    output logic [71:0]  m_tdata,
    output logic         m_tlast
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_LOAD, ST_EVAL, ST_DIV, ST_MUL, ST_FIN, ST_COMMIT, ST_FLUSH
    } state_t;

    logic [2:0]       in_channel;
    logic [1:0]       in_mode;
    logic [PER_W-1:0] in_period;
    logic [CNT_W-1:0] in_count;
    logic [PER_W-1:0] in_start;
    logic             in_immediate;
    logic [PER_W-1:0] in_elapsed;

    assign in_channel   = s_tdata[2:0];
    assign in_mode      = s_tdata[4:3];
    assign in_period    = s_tdata[36:5];
    assign in_count     = s_tdata[52:37];
    assign in_start     = s_tdata[84:53];
    assign in_immediate = s_tdata[85];
    assign in_elapsed   = s_tdata[117:86];

    state_t            state_reg;
    logic [CHANNELS-1:0] active_reg;
    logic [AW-1:0]     idx_reg;
    logic              tick_reg;
    logic [PER_W-1:0]  el_reg;
    logic [1:0]        mode_reg;
    logic [PER_W-1:0]  per_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [PER_W-1:0]  carry_reg;
    logic [AMT_W-1:0]  prod_reg;
    logic              res_valid_reg;
    logic [CNT_W-1:0]  res_times_reg;
    logic [AMT_W-1:0]  res_amount_reg;
    logic              pend_valid_reg;
    logic [2:0]        pend_ch_reg;
    logic [CNT_W-1:0]  pend_times_reg;
    logic [AMT_W-1:0]  pend_amount_reg;
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;
    logic              m_tlast_reg;

    chan_rec_t rec_mem [CHANNELS];
    chan_rec_t rd_reg;
    chan_rec_t wr_data;
    logic      wr_en;
    logic [AW-1:0] wr_addr;

    logic [AW+2:0] ch_wide;
    logic [AW-1:0] ch_addr;
    logic [AW+2:0] idx_wide;
    logic [2:0]    cur_ch;
    logic          accept;
    logic          add_ok;
    logic          out_free;
    logic          push_out;
    logic          div_start;
    logic [QUO_W-1:0] div_q;
    logic [PER_W-1:0] div_r;
    logic          div_done;
    logic [QUO_W-1:0] rem_wide;
    logic          q_covers;
    logic [ACC_W:0] sat_sum;

    assign ch_wide  = {{AW{1'b0}}, in_channel};
    assign ch_addr  = ch_wide[AW-1:0];
    assign idx_wide = {3'b000, idx_reg};
    assign cur_ch   = idx_wide[2:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign add_ok   = ({29'd0, in_channel} < 32'(CHANNELS)) && !active_reg[ch_addr]
                      && (in_period != '0) && (in_count != '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign push_out = out_free && pend_valid_reg
                      && ((state_reg == ST_COMMIT && res_valid_reg) || state_reg == ST_FLUSH);
    assign rem_wide = {{(QUO_W-CNT_W){1'b0}}, rem_reg};
    assign q_covers = div_q >= rem_wide;
    assign sat_sum  = {1'b0, rd_reg.accumulated} + {{(ACC_W+1-PER_W){1'b0}}, el_reg};
    assign div_start = (state_reg == ST_EVAL) && (acc_reg >= {8'd0, per_reg})
                       && (mode_reg != MODE_INTERVAL);

    mmet_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  ((mode_reg == MODE_LUMPED)
                    ? ({1'b0, acc_reg} + {9'd0, carry_reg}) : {1'b0, acc_reg}),
        .divisor   (per_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '{mode: mode_reg, period: per_reg, remaining: rem_reg,
                    accumulated: acc_reg, carry: carry_reg};
        if (accept && s_tuser == KIND_ADD && add_ok) begin
            wr_en   = 1'b1;
            wr_addr = ch_addr;
            wr_data = '{mode: in_mode, period: in_period, remaining: in_count,
                        accumulated: {8'd0, in_start}, carry: '0};
        end else if (state_reg == ST_COMMIT) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[wr_addr] <= wr_data;
        end
        rd_reg <= rec_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            idx_reg        <= '0;
            tick_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end else begin
            if (push_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_valid_reg <= 1'b0;
                        if (s_tuser == KIND_TICK) begin
                            tick_reg  <= 1'b1;
                            el_reg    <= in_elapsed;
                            idx_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end else if (add_ok) begin
                            tick_reg          <= 1'b0;
                            active_reg[ch_addr] <= 1'b1;
                            idx_reg           <= ch_addr;
                            mode_reg          <= in_mode;
                            per_reg           <= in_period;
                            rem_reg           <= in_count;
                            acc_reg           <= {8'd0, in_start};
                            carry_reg         <= '0;
                            state_reg         <= in_immediate ? ST_EVAL : ST_IDLE;
                        end
                    end
                end
                ST_SCAN: begin
                    res_valid_reg <= 1'b0;
                    if (active_reg[idx_reg]) begin
                        state_reg <= ST_LOAD;
                    end else if (idx_reg == AW'(CHANNELS - 1)) begin
                        state_reg <= ST_FLUSH;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_LOAD: begin
                    mode_reg  <= rd_reg.mode;
                    per_reg   <= rd_reg.period;
                    rem_reg   <= rd_reg.remaining;
                    carry_reg <= rd_reg.carry;
                    acc_reg   <= sat_sum[ACC_W] ? '1 : sat_sum[ACC_W-1:0];
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (acc_reg < {8'd0, per_reg}) begin
                        state_reg <= ST_COMMIT;
                    end else if (mode_reg == MODE_INTERVAL) begin
                        res_valid_reg  <= 1'b1;
                        res_times_reg  <= CNT_W'(1);
                        res_amount_reg <= {16'd0, per_reg};
                        acc_reg        <= '0;
                        rem_reg        <= rem_reg - 1'b1;
                        state_reg      <= ST_COMMIT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (q_covers) begin
                            state_reg <= ST_MUL;
                        end else begin
                            res_valid_reg <= 1'b1;
                            rem_reg       <= rem_reg - div_q[CNT_W-1:0];
                            if (mode_reg == MODE_LUMPED) begin
                                res_times_reg  <= CNT_W'(1);
                                res_amount_reg <= {8'd0, acc_reg};
                                carry_reg      <= div_r;
                                acc_reg        <= '0;
                            end else begin
                                res_times_reg  <= div_q[CNT_W-1:0];
                                res_amount_reg <= {16'd0, per_reg};
                                acc_reg        <= {8'd0, div_r};
                            end
                            state_reg <= ST_COMMIT;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg  <= {16'd0, per_reg} * {32'd0, rem_reg};
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    res_valid_reg <= 1'b1;
                    rem_reg       <= '0;
                    if (mode_reg == MODE_LUMPED) begin
                        res_times_reg  <= CNT_W'(1);
                        res_amount_reg <= prod_reg - {16'd0, carry_reg};
                        carry_reg      <= '0;
                        acc_reg        <= '0;
                    end else begin
                        res_times_reg  <= rem_reg;
                        res_amount_reg <= {16'd0, per_reg};
                        acc_reg        <= acc_reg - prod_reg[ACC_W-1:0];
                    end
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (!(res_valid_reg && pend_valid_reg && !out_free)) begin
                        if (rem_reg == '0) begin
                            active_reg[idx_reg] <= 1'b0;
                        end
                        if (res_valid_reg) begin
                            if (pend_valid_reg) begin
                                m_tlast_reg  <= 1'b0;
                                m_tdata_reg  <= {5'd0, pend_amount_reg, pend_times_reg,
                                                 pend_ch_reg};
                            end
                            pend_valid_reg  <= 1'b1;
                            pend_ch_reg     <= cur_ch;
                            pend_times_reg  <= res_times_reg;
                            pend_amount_reg <= res_amount_reg;
                        end
                        if (tick_reg && idx_reg != AW'(CHANNELS - 1)) begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_tlast_reg    <= 1'b1;
                        m_tdata_reg    <= {5'd0, pend_amount_reg, pend_times_reg, pend_ch_reg};
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> bench/mmet_checker.sv
// Result checker of the multi-mode event timer: predicts firings and compares results.
module mmet_checker
    import mmet_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] times;
        logic [47:0] amount;
        logic        last;
    } firing_t;

    logic      busy [8];
    chan_rec_t rec  [8];
    firing_t   firing_q [$];

    assign pending = firing_q.size();

    task automatic eval_channel(input int ch, inout int made);
        logic [63:0] per, acc, rem, sum, d, f;
        firing_t     r;
        per = 64'(rec[ch].period);
        acc = 64'(rec[ch].accumulated);
        rem = 64'(rec[ch].remaining);
        r = '0;
        r.chan = 3'(ch);
        if (rec[ch].mode != MODE_INTERVAL && rec[ch].mode != MODE_LUMPED) begin
            f = acc / per;
            if (f > rem) f = rem;
            if (f > 0) begin
                rec[ch].accumulated = 40'(acc - f * per);
                rem = rem - f;
                r.times = 16'(f);
                r.amount = 48'(per);
                firing_q.push_back(r);
                made++;
            end
        end else if (rec[ch].mode == MODE_INTERVAL) begin
            if (acc >= per) begin
                rec[ch].accumulated = '0;
                rem = rem - 1;
                r.times = 16'd1;
                r.amount = 48'(per);
                firing_q.push_back(r);
                made++;
            end
        end else if (acc >= per) begin
            sum = acc + 64'(rec[ch].carry);
            d = sum / per;
            r.times = 16'd1;
            if (d >= rem) begin
                r.amount = 48'(per * rem - 64'(rec[ch].carry));
                rem = 0;
                rec[ch].carry = '0;
            end else begin
                r.amount = 48'(acc);
                rem = rem - d;
                rec[ch].carry = 32'(sum % per);
            end
            rec[ch].accumulated = '0;
            firing_q.push_back(r);
            made++;
        end
        rec[ch].remaining = 16'(rem);
        if (rem == 0) busy[ch] = 1'b0;
    endtask

    task automatic predict_request(input logic kind, input logic [119:0] d);
        int          made;
        int          ch;
        logic [40:0] sat;
        firing_t     r;
        made = 0;
        ch = int'(d[2:0]);
        if (kind == KIND_ADD) begin
            if (!busy[ch] && d[36:5] != 0 && d[52:37] != 0) begin
                busy[ch] = 1'b1;
                rec[ch].mode = d[4:3];
                rec[ch].period = d[36:5];
                rec[ch].remaining = d[52:37];
                rec[ch].accumulated = 40'(d[84:53]);
                rec[ch].carry = '0;
                if (d[85]) eval_channel(ch, made);
            end
        end else begin
            for (int c = 0; c < 8; c++) begin
                if (busy[c]) begin
                    sat = 41'(rec[c].accumulated) + 41'(d[117:86]);
                    rec[c].accumulated = sat[40] ? '1 : sat[39:0];
                    eval_channel(c, made);
                end
            end
        end
        if (made > 0) begin
            r = firing_q.pop_back();
            r.last = 1'b1;
            firing_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        firing_t want;
        if (!aresetn) begin
            fail_count <= 0;
            firing_q.delete();
            for (int c = 0; c < 8; c++) busy[c] = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (firing_q.size() == 0) begin
                    $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = firing_q.pop_front();
                    if (m_tdata[2:0] != want.chan || m_tdata[18:3] != want.times ||
                        m_tdata[66:19] != want.amount || m_tlast != want.last) begin
                        $display("%0t: expected ch %0d times %0d amount %0d last %b,",
                                 $time, want.chan, want.times, want.amount, want.last);
                        $display("%0t:   actual ch %0d times %0d amount %0d last %b",
                                 $time, m_tdata[2:0], m_tdata[18:3], m_tdata[66:19],
                                 m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
        end
    end

endmodule

>>> bench/tb.sv
// Testbench top of the multi-mode event timer: stimulus, back pressure and verdict.
module tb;
    import mmet_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           hold_off = 1'b0;
    bit           no_gaps = 1'b0;

    always #5 aclk = ~aclk;

    multi_mode_event_timer i_dut (.*);

    mmet_checker i_chk (.*);

    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= no_gaps || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1, 9));
            3: return 32'($urandom_range(10, 300));
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input logic kind, input logic [2:0] ch, input logic [1:0] mode,
                        input logic [31:0] per, input logic [15:0] cnt,
                        input logic [31:0] start, input logic imm,
                        input logic [31:0] el);
        while (!no_gaps && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {2'b00, el, imm, start, cnt, per, mode, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic add_random();
        logic [31:0] per;
        per = rand_word();
        if ($urandom_range(15) == 0) per = 32'd0;
        send(KIND_ADD, 3'($urandom_range(7)), 2'($urandom_range(3)), per,
             $urandom_range(15) == 0 ? 16'($urandom_range(0, 1) ? 0 : 16'hFFFF)
                                     : 16'($urandom_range(1, 6)),
             $urandom_range(1) ? rand_word() : 32'($urandom_range(0, 20)),
             1'($urandom_range(1)), $urandom());
    endtask

    task automatic tick_random();
        send(KIND_TICK, 3'($urandom()), 2'($urandom()), $urandom(), 16'($urandom()),
             $urandom(), 1'($urandom()), rand_word());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send(KIND_ADD, 3'd0, 2'd0, 32'd3, 16'd4, 32'd10, 1'b1, 32'd0);
        send(KIND_ADD, 3'd0, 2'd1, 32'd5, 16'd2, 32'd0, 1'b0, 32'd0);
        send(KIND_ADD, 3'd1, 2'd1, 32'd0, 16'd2, 32'd0, 1'b1, 32'd0);
        send(KIND_ADD, 3'd1, 2'd2, 32'd7, 16'd0, 32'd0, 1'b1, 32'd0);
        send(KIND_ADD, 3'd1, 2'd2, 32'd7, 16'd2, 32'd9, 1'b1, 32'd0);
        send(KIND_ADD, 3'd2, 2'd3, 32'd4, 16'd5, 32'd6, 1'b1, 32'd0);
        send(KIND_ADD, 3'd3, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'd0);
        send(KIND_ADD, 3'd7, 2'd0, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        send(KIND_ADD, 3'd4, 2'd2, 32'd1, 16'd1, 32'd0, 1'b0, 32'd0);
        send(KIND_TICK, 3'd7, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0);
        send(KIND_TICK, 3'd0, 2'd0, 32'd0, 16'd0, 32'd0, 1'b0, 32'd5);
        for (int i = 0; i < 6; i++)
            send(KIND_TICK, 3'd0, 2'd0, 32'd0, 16'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
        send(KIND_ADD, 3'd5, 2'd3, 32'd3, 16'd10, 32'd0, 1'b0, 32'd0);
        send(KIND_TICK, 3'd0, 2'd0, 32'd0, 16'd0, 32'd0, 1'b0, 32'd4);
        send(KIND_TICK, 3'd0, 2'd0, 32'd0, 16'd0, 32'd0, 1'b0, 32'd5);
        send(KIND_TICK, 3'd0, 2'd0, 32'd0, 16'd0, 32'd0, 1'b0, 32'd100);
        for (int i = 0; i < 100; i++) begin
            if (i == 40) begin
                no_gaps = 1'b1;
                hold_off = 1'b1;
                fork
                    begin
                        repeat (600) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (i == 80) no_gaps = 1'b0;
            if ($urandom_range(99) < 55) add_random();
            else tick_random();
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
